FILE: rtl/sir_pkg.sv
// Shared types, widths and latency constants for the sphere impulse response block.
// Used by every module under rtl/. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sir_pkg;

  localparam int unsigned VelW   = 32;
  localparam int unsigned NormW  = 16;
  localparam int unsigned MassW  = 32;
  localparam int unsigned RestW  = 16;

  localparam logic [RestW-1:0] RestReset = 16'd26214;

  // Mass ratio: Q.20 fraction, up to and including one.
  localparam int unsigned FracW  = 20;
  localparam int unsigned QuotW  = FracW + 1;
  localparam int unsigned DenW   = MassW + 1;
  localparam int unsigned DivLat = QuotW + 1;

  localparam int unsigned MagW   = 36;
  localparam int unsigned ScaleW = 39;
  localparam int unsigned DeltaW = 42;

  localparam int unsigned FrontLat   = 6;
  localparam int unsigned BackLat    = 5;
  localparam int unsigned DelayDepth = 1 + DivLat - FrontLat;
  // Edges from the one that takes a request to the one that takes its result.
  localparam int unsigned ResultLat  = 2 + DivLat + BackLat;

  typedef struct packed {
    logic signed [VelW-1:0]  vel_a_x;
    logic signed [VelW-1:0]  vel_a_y;
    logic signed [VelW-1:0]  vel_a_z;
    logic signed [VelW-1:0]  vel_b_x;
    logic signed [VelW-1:0]  vel_b_y;
    logic signed [VelW-1:0]  vel_b_z;
    logic signed [NormW-1:0] norm_x;
    logic signed [NormW-1:0] norm_y;
    logic signed [NormW-1:0] norm_z;
    logic [MassW-1:0]        mass_a;
    logic [MassW-1:0]        mass_b;
    logic [1:0]              fixed_flags;
  } req_t;

  typedef struct packed {
    logic signed [VelW-1:0] new_a_x;
    logic signed [VelW-1:0] new_a_y;
    logic signed [VelW-1:0] new_a_z;
    logic signed [VelW-1:0] new_b_x;
    logic signed [VelW-1:0] new_b_y;
    logic signed [VelW-1:0] new_b_z;
    logic                   impulse_applied;
    logic                   saturated;
  } res_t;

  // Item state handed from the front stages to the update stages.
  typedef struct packed {
    logic [2:0][VelW-1:0]  va;
    logic [2:0][VelW-1:0]  vb;
    logic [2:0][NormW-1:0] nrm;
    logic [ScaleW-1:0]     scale;
    logic [1:0]            flags;
    logic                  applied;
  } mid_t;

endpackage

`default_nettype wire

FILE: rtl/sir_divider.sv
// Pipelined restoring divider for the Q.20 mass ratio, one quotient bit per stage.
// Depends on sir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sir_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [sir_pkg::MassW-1:0]   num_i,
  input  logic [sir_pkg::DenW-1:0]    den_i,
  output logic                        valid_o,
  output logic [sir_pkg::QuotW-1:0]   quo_o
);

  localparam int unsigned QW = sir_pkg::QuotW;
  localparam int unsigned DW = sir_pkg::DenW;
  localparam int unsigned NW = sir_pkg::MassW + sir_pkg::FracW + 1;

  logic [NW-1:0] dividend;

  logic [DW-1:0] rem_q  [QW+1];
  logic [QW-1:0] low_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic          zero_q [QW+1];
  logic [QW:0]   vld_q;

  // Rounded dividend: num * 2^20 + den / 2.
  assign dividend = NW'({num_i, sir_pkg::FracW'(0)}) + NW'(den_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= DW'(dividend[NW-1:QW]);
    low_q[0]  <= dividend[QW-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    zero_q[0] <= (den_i == '0);
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_q[j-1], low_q[j-1][QW-j]};
      ge    = (trial >= {1'b0, den_q[j-1]});
    end

    always_ff @(posedge clk_i) begin
      rem_q[j]  <= ge ? DW'(trial - {1'b0, den_q[j-1]}) : DW'(trial);
      low_q[j]  <= low_q[j-1];
      quo_q[j]  <= {quo_q[j-1][QW-2:0], ge};
      den_q[j]  <= den_q[j-1];
      zero_q[j] <= zero_q[j-1];
    end
  end

  // Two massless bodies share the impulse equally.
  assign quo_o   = zero_q[QW] ? QW'(1 << (sir_pkg::FracW - 1)) : quo_q[QW];
  assign valid_o = vld_q[QW];

endmodule

`default_nettype wire

FILE: rtl/sir_delay.sv
// Delay line that keeps item state and its valid bit level with the divider.
// Depends on sir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sir_delay #(
  parameter int unsigned Width = $bits(sir_pkg::mid_t),
  parameter int unsigned Depth = sir_pkg::DelayDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] data_q [Depth];
  logic [Depth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < Depth; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int k = 1; k < Depth; k++) begin
      data_q[k] <= data_q[k-1];
    end
  end

  assign valid_o = vld_q[Depth-1];
  assign data_o  = data_q[Depth-1];

endmodule

`default_nettype wire

FILE: rtl/sir_front.sv
// Front stages: relative normal velocity, path decision and restitution scale.
// Also feeds the mass-ratio dividers. Depends on sir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sir_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  sir_pkg::req_t               req_i,
  input  logic [sir_pkg::RestW-1:0]   rest_i,
  output logic                        div_valid_o,
  output logic [sir_pkg::MassW-1:0]   mass_a_o,
  output logic [sir_pkg::MassW-1:0]   mass_b_o,
  output logic [sir_pkg::DenW-1:0]    den_o,
  output logic                        valid_o,
  output sir_pkg::mid_t               mid_o
);

  logic [sir_pkg::FrontLat-1:0] vld_q;

  sir_pkg::mid_t mid1_q, mid2_q, mid3_q, mid4_q, mid5_q, mid6_q;
  sir_pkg::mid_t mid_in, mid4_d, mid6_d;

  logic signed [sir_pkg::VelW:0]  d1_q [3];
  logic signed [47:0]             p2_q [3];
  logic signed [49:0]             vn3_q;
  logic [sir_pkg::MagW-1:0]       mag4_q;
  logic [52:0]                    sraw5_q;
  logic [sir_pkg::MassW-1:0]      ma1_q, mb1_q;
  logic [sir_pkg::DenW-1:0]       den1_q;

  logic signed [50:0]             negv;
  logic [50:0]                    mrnd;
  logic                           applied;
  logic [53:0]                    srnd;

  always_comb begin
    mid_in         = '0;
    mid_in.va[0]   = req_i.vel_a_x;
    mid_in.va[1]   = req_i.vel_a_y;
    mid_in.va[2]   = req_i.vel_a_z;
    mid_in.vb[0]   = req_i.vel_b_x;
    mid_in.vb[1]   = req_i.vel_b_y;
    mid_in.vb[2]   = req_i.vel_b_z;
    mid_in.nrm[0]  = req_i.norm_x;
    mid_in.nrm[1]  = req_i.norm_y;
    mid_in.nrm[2]  = req_i.norm_z;
    mid_in.flags   = req_i.fixed_flags;
  end

  // Approaching or touching bodies take the impulse unless both are static.
  always_comb begin
    negv    = -(51'(vn3_q));
    mrnd    = $unsigned(negv) + 51'd8192;
    applied = !(mid3_q.flags[0] && mid3_q.flags[1]) && (vn3_q <= 50'sd0);
    mid4_d  = mid3_q;
    mid4_d.applied = applied;
  end

  always_comb begin
    srnd         = 54'(sraw5_q) + 54'd16384;
    mid6_d       = mid5_q;
    mid6_d.scale = srnd[53:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[sir_pkg::FrontLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mid1_q <= mid_in;
    for (int i = 0; i < 3; i++) begin
      d1_q[i] <= $signed({mid_in.vb[i][sir_pkg::VelW-1], mid_in.vb[i]})
               - $signed({mid_in.va[i][sir_pkg::VelW-1], mid_in.va[i]});
    end
    ma1_q  <= req_i.mass_a;
    mb1_q  <= req_i.mass_b;
    den1_q <= sir_pkg::DenW'(req_i.mass_a) + sir_pkg::DenW'(req_i.mass_b);

    mid2_q <= mid1_q;
    for (int i = 0; i < 3; i++) begin
      p2_q[i] <= d1_q[i] * $signed(mid1_q.nrm[i]);
    end

    mid3_q <= mid2_q;
    vn3_q  <= 50'(p2_q[0]) + 50'(p2_q[1]) + 50'(p2_q[2]);

    mid4_q <= mid4_d;
    mag4_q <= applied ? mrnd[49:14] : '0;

    mid5_q  <= mid4_q;
    sraw5_q <= mag4_q * ({1'b0, rest_i} + 17'd32768);

    mid6_q <= mid6_d;
  end

  assign div_valid_o = vld_q[0];
  assign mass_a_o    = ma1_q;
  assign mass_b_o    = mb1_q;
  assign den_o       = den1_q;
  assign valid_o     = vld_q[sir_pkg::FrontLat-1];
  assign mid_o       = mid6_q;

endmodule

`default_nettype wire

FILE: rtl/sir_back.sv
// Update stages: impulse share per body, per-axis change and saturating add.
// Depends on sir_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sir_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  sir_pkg::mid_t              mid_i,
  input  logic [sir_pkg::QuotW-1:0]  ratio_a_i,
  input  logic [sir_pkg::QuotW-1:0]  ratio_b_i,
  output logic                       valid_o,
  output sir_pkg::res_t              res_o
);

  localparam int unsigned PW  = sir_pkg::ScaleW + sir_pkg::QuotW;
  localparam int unsigned NKW = sir_pkg::NormW + sir_pkg::ScaleW;
  localparam int unsigned SW  = sir_pkg::DeltaW + 2;

  logic [sir_pkg::BackLat-1:0] vld_q;

  sir_pkg::mid_t mid1_q, mid2_q, mid3_q, mid4_q;
  logic [PW-1:0]                   pa1_q, pb1_q;
  logic [sir_pkg::ScaleW-1:0]      ka2_q, kb2_q;
  logic [NKW-1:0]                  nka3_q [3];
  logic [NKW-1:0]                  nkb3_q [3];
  logic signed [sir_pkg::DeltaW:0] da4_q [3];
  logic signed [sir_pkg::DeltaW:0] db4_q [3];
  sir_pkg::res_t                   res_q;

  logic [PW-1:0]                   pa_rnd, pb_rnd;
  logic [sir_pkg::ScaleW-1:0]      ka_d, kb_d;
  logic [sir_pkg::NormW-1:0]       nmag [3];
  logic [NKW:0]                    ra_rnd [3];
  logic [NKW:0]                    rb_rnd [3];
  logic signed [SW-1:0]            suma [3];
  logic signed [SW-1:0]            sumb [3];
  logic [sir_pkg::VelW-1:0]        outa [3];
  logic [sir_pkg::VelW-1:0]        outb [3];
  logic                            clip;

  // Only the dynamic bodies move; with both dynamic the ratios split the impulse.
  always_comb begin
    pa_rnd = pa1_q + PW'(1 << (sir_pkg::FracW - 1));
    pb_rnd = pb1_q + PW'(1 << (sir_pkg::FracW - 1));
    priority if (!mid1_q.flags[0] && !mid1_q.flags[1]) begin
      ka_d = pa_rnd[sir_pkg::FracW +: sir_pkg::ScaleW];
      kb_d = pb_rnd[sir_pkg::FracW +: sir_pkg::ScaleW];
    end else if (mid1_q.flags[0]) begin
      ka_d = '0;
      kb_d = mid1_q.scale;
    end else begin
      ka_d = mid1_q.scale;
      kb_d = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i]   = mid2_q.nrm[i][sir_pkg::NormW-1] ? (~mid2_q.nrm[i] + 1'b1)
                                                  : mid2_q.nrm[i];
      ra_rnd[i] = (NKW + 1)'(nka3_q[i]) + (NKW + 1)'(8192);
      rb_rnd[i] = (NKW + 1)'(nkb3_q[i]) + (NKW + 1)'(8192);
    end
  end

  // Saturate each sum to the signed 32-bit range and note any clamp.
  always_comb begin
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      suma[i] = SW'($signed(mid4_q.va[i])) - SW'(da4_q[i]);
      sumb[i] = SW'($signed(mid4_q.vb[i])) + SW'(db4_q[i]);
      priority if (suma[i] > SW'(64'sd2147483647)) begin
        outa[i] = 32'h7FFF_FFFF;
        clip    = 1'b1;
      end else if (suma[i] < SW'(-64'sd2147483648)) begin
        outa[i] = 32'h8000_0000;
        clip    = 1'b1;
      end else begin
        outa[i] = suma[i][sir_pkg::VelW-1:0];
      end
      priority if (sumb[i] > SW'(64'sd2147483647)) begin
        outb[i] = 32'h7FFF_FFFF;
        clip    = 1'b1;
      end else if (sumb[i] < SW'(-64'sd2147483648)) begin
        outb[i] = 32'h8000_0000;
        clip    = 1'b1;
      end else begin
        outb[i] = sumb[i][sir_pkg::VelW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[sir_pkg::BackLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mid1_q <= mid_i;
    pa1_q  <= PW'(mid_i.scale) * PW'(ratio_a_i);
    pb1_q  <= PW'(mid_i.scale) * PW'(ratio_b_i);

    mid2_q <= mid1_q;
    ka2_q  <= ka_d;
    kb2_q  <= kb_d;

    mid3_q <= mid2_q;
    for (int i = 0; i < 3; i++) begin
      nka3_q[i] <= NKW'(nmag[i]) * NKW'(ka2_q);
      nkb3_q[i] <= NKW'(nmag[i]) * NKW'(kb2_q);
    end

    mid4_q <= mid3_q;
    for (int i = 0; i < 3; i++) begin
      da4_q[i] <= mid3_q.nrm[i][sir_pkg::NormW-1]
                ? -$signed({1'b0, ra_rnd[i][14 +: sir_pkg::DeltaW]})
                :  $signed({1'b0, ra_rnd[i][14 +: sir_pkg::DeltaW]});
      db4_q[i] <= mid3_q.nrm[i][sir_pkg::NormW-1]
                ? -$signed({1'b0, rb_rnd[i][14 +: sir_pkg::DeltaW]})
                :  $signed({1'b0, rb_rnd[i][14 +: sir_pkg::DeltaW]});
    end

    res_q.new_a_x         <= outa[0];
    res_q.new_a_y         <= outa[1];
    res_q.new_a_z         <= outa[2];
    res_q.new_b_x         <= outb[0];
    res_q.new_b_y         <= outb[1];
    res_q.new_b_z         <= outb[2];
    res_q.impulse_applied <= mid4_q.applied;
    res_q.saturated       <= clip;
  end

  assign valid_o = vld_q[sir_pkg::BackLat-1];
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: rtl/sphere_impulse_response.sv
// The request is registered at the input, then passes the front stages and the mass-ratio dividers,
// kept in step by the delay line, and then the update stages, whose last register drives res_o.
// Throughput: one request per cycle; busy stays low and no request is ever refused.
// The depth is set by the mass-ratio divider, one quotient bit per pipeline stage.
// The receiver cannot stall: each result shows for exactly one cycle with res_valid_o.
// Reset clears all valid bits and sets the restitution register to 0.8.
// Top level; depends on sir_pkg, sir_front, sir_divider, sir_delay and sir_back.
`timescale 1ns / 1ps
`default_nettype none

module sphere_impulse_response (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  sir_pkg::req_t              req_i,
  output logic                       res_valid_o,
  output sir_pkg::res_t              res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [sir_pkg::RestW-1:0]  cfg_data_i
);

  logic [sir_pkg::RestW-1:0] rest_q;
  sir_pkg::req_t             req_q;
  logic                      in_vld_q;
  logic                      accept;

  logic                      div_valid;
  logic [sir_pkg::MassW-1:0] mass_a, mass_b;
  logic [sir_pkg::DenW-1:0]  den;
  logic                      front_valid;
  sir_pkg::mid_t             front_mid;
  logic                      dva_valid, dvb_valid;
  logic [sir_pkg::QuotW-1:0] ratio_a, ratio_b;
  logic                      mid_valid;
  logic [$bits(sir_pkg::mid_t)-1:0] mid_bits;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q   <= sir_pkg::RestReset;
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
      if (cfg_valid_i && cfg_ready_o) begin
        rest_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_i;
  end

  sir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_vld_q),
    .req_i       (req_q),
    .rest_i      (rest_q),
    .div_valid_o (div_valid),
    .mass_a_o    (mass_a),
    .mass_b_o    (mass_b),
    .den_o       (den),
    .valid_o     (front_valid),
    .mid_o       (front_mid)
  );

  // Body A moves by the share mb / (ma + mb), body B by ma / (ma + mb).
  sir_divider u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .num_i   (mass_b),
    .den_i   (den),
    .valid_o (dva_valid),
    .quo_o   (ratio_a)
  );

  sir_divider u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .num_i   (mass_a),
    .den_i   (den),
    .valid_o (dvb_valid),
    .quo_o   (ratio_b)
  );

  sir_delay #(
    .Width ($bits(sir_pkg::mid_t)),
    .Depth (sir_pkg::DelayDepth)
  ) u_delay (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .data_i  (front_mid),
    .valid_o (mid_valid),
    .data_o  (mid_bits)
  );

  sir_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (mid_valid),
    .mid_i     (sir_pkg::mid_t'(mid_bits)),
    .ratio_a_i (ratio_a),
    .ratio_b_i (ratio_b),
    .valid_o   (res_valid_o),
    .res_o     (res_o)
  );

  // The divider outputs and the delayed item state must line up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_valid == dva_valid) && (mid_valid == dvb_valid))
    else $error("divider and delay line out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(sir_pkg::ResultLat) res_valid_o)
    else $error("request produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.impulse_applied |-> !res_o.saturated)
    else $error("clamp reported on a skipped collision");

endmodule

`default_nettype wire

FILE: sim/sir_checker.sv
// Checker for the sphere impulse response block: watches the request, config and result ports.
// Predicts each result from its own model of the arithmetic and compares field by field.
// Depends on sir_pkg.
`timescale 1ns / 1ps

module sir_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  sir_pkg::req_t   req_i,
  input  logic            res_valid_o,
  input  sir_pkg::res_t   res_o,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_o,
  input  logic [15:0]     cfg_data_i,
  output int              fail_count,
  output int              pending_count,
  output int              result_count
);

  logic [15:0]   rest_q;
  sir_pkg::res_t expected_q[$];

  function automatic logic [63:0] mass_frac(input logic [63:0] num, input logic [63:0] den);
    if (den == 0) return 64'd1 << 19;
    return ((num << 20) + (den >> 1)) / den;
  endfunction

  function automatic longint normal_delta(input longint n, input logic [63:0] k);
    logic [63:0] un;
    logic [63:0] d;
    un = (n < 0) ? -n : n;
    d = (un * k + (64'd1 << 13)) >> 14;
    return (n < 0) ? -longint'(d) : longint'(d);
  endfunction

  function automatic longint clamp32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic sir_pkg::res_t collide(input sir_pkg::req_t r, input logic [15:0] e);
    longint va[3], vb[3], nv[3], out[6];
    longint vn;
    logic [63:0] mag, s, ka, kb, ma, mb;
    logic sa, sb, sat;
    sir_pkg::res_t o;
    va[0] = longint'($signed(r.vel_a_x));
    va[1] = longint'($signed(r.vel_a_y));
    va[2] = longint'($signed(r.vel_a_z));
    vb[0] = longint'($signed(r.vel_b_x));
    vb[1] = longint'($signed(r.vel_b_y));
    vb[2] = longint'($signed(r.vel_b_z));
    nv[0] = longint'($signed(r.norm_x));
    nv[1] = longint'($signed(r.norm_y));
    nv[2] = longint'($signed(r.norm_z));
    ma = 64'(r.mass_a); mb = 64'(r.mass_b);
    sa = r.fixed_flags[0]; sb = r.fixed_flags[1];
    sat = 1'b0; vn = 0; ka = 0; kb = 0;
    for (int i = 0; i < 3; i++) begin
      vn += (vb[i] - va[i]) * nv[i];
      out[i] = va[i];
      out[3+i] = vb[i];
    end
    o.impulse_applied = 1'b0;
    if (!(sa && sb) && vn <= 0) begin
      mag = (64'(-vn) + (64'd1 << 13)) >> 14;
      s = (mag * (64'd32768 + 64'(e)) + (64'd1 << 14)) >> 15;
      o.impulse_applied = 1'b1;
      if (!sa && !sb) begin
        ka = (s * mass_frac(mb, ma + mb) + (64'd1 << 19)) >> 20;
        kb = (s * mass_frac(ma, ma + mb) + (64'd1 << 19)) >> 20;
      end else if (sa) kb = s;
      else ka = s;
      for (int i = 0; i < 3; i++) begin
        out[i] = clamp32(va[i] - normal_delta(nv[i], ka), sat);
        out[3+i] = clamp32(vb[i] + normal_delta(nv[i], kb), sat);
      end
    end
    o.new_a_x = 32'(out[0]); o.new_a_y = 32'(out[1]); o.new_a_z = 32'(out[2]);
    o.new_b_x = 32'(out[3]); o.new_b_y = 32'(out[4]); o.new_b_z = 32'(out[5]);
    o.saturated = sat;
    return o;
  endfunction

  function automatic bit field_bad(input string name, input logic [31:0] want,
                                   input logic [31:0] got);
    if (got !== want) begin
      $error("field %s: expected %0h, actual %0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sir_pkg::res_t want;
    sir_pkg::res_t got;
    bit bad;
    if (!rst_ni) begin
      rest_q <= sir_pkg::RestReset;
      fail_count = 0;
      result_count = 0;
      expected_q.delete();
    end else begin
      if (res_valid_o) begin
        got = res_o;
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          bad = field_bad("new_a_x", want.new_a_x, got.new_a_x)
              | field_bad("new_a_y", want.new_a_y, got.new_a_y)
              | field_bad("new_a_z", want.new_a_z, got.new_a_z)
              | field_bad("new_b_x", want.new_b_x, got.new_b_x)
              | field_bad("new_b_y", want.new_b_y, got.new_b_y)
              | field_bad("new_b_z", want.new_b_z, got.new_b_z)
              | field_bad("impulse_applied", 32'(want.impulse_applied),
                          32'(got.impulse_applied))
              | field_bad("saturated", 32'(want.saturated), 32'(got.saturated));
          if (bad) fail_count++;
        end
      end
      if (start && !busy) expected_q = {expected_q, collide(req_i, rest_q)};
      if (cfg_valid_i && cfg_ready_o) rest_q <= cfg_data_i;
    end
    pending_count = expected_q.size();
  end
endmodule

FILE: sim/testbench.sv
// Top of the sphere impulse response testbench: clock, reset, request and config stimulus.
// Depends on sir_pkg, sphere_impulse_response and sir_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int CycleLimit = 200000;

  logic clk_i, rst_ni, start, busy, res_valid_o, cfg_valid_i, cfg_ready_o;
  logic [15:0] cfg_data_i;
  sir_pkg::req_t req_i;
  sir_pkg::res_t res_o;
  int fail_count, pending_count, result_count, cycle_count;
  int requests_sent, settings_used;

  sphere_impulse_response DUT (.*);
  sir_checker checker_inst (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("[sphere_impulse_response] ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_norm();
    case ($urandom_range(0, 7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return 32'hffffffff;
      1: return $urandom_range(0, 3);
      2: return $urandom_range(32'h100, 32'h100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic sir_pkg::req_t rand_request();
    sir_pkg::req_t r;
    r.vel_a_x = rand_vel(); r.vel_a_y = rand_vel(); r.vel_a_z = rand_vel();
    r.vel_b_x = rand_vel(); r.vel_b_y = rand_vel(); r.vel_b_z = rand_vel();
    r.norm_x = rand_norm(); r.norm_y = rand_norm(); r.norm_z = rand_norm();
    r.mass_a = rand_mass(); r.mass_b = rand_mass();
    r.fixed_flags = 2'($urandom_range(0, 3));
    // Mostly mirrored pairs, B moving opposite to A, so the impulse path gets exercised.
    if ($urandom_range(0, 3) != 0) begin
      r.vel_b_x = -r.vel_a_x; r.vel_b_y = -r.vel_a_y; r.vel_b_z = -r.vel_a_z;
      if ($urandom_range(0, 1)) r.norm_x = -r.norm_x;
    end
    return r;
  endfunction

  task automatic send(input sir_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic pause_start(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_rest(input logic [15:0] v);
    while (pending_count != 0) @(posedge clk_i);
    repeat (sir_pkg::ResultLat + 4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  task automatic directed_set();
    sir_pkg::req_t r;
    r = '0;
    r.mass_a = 32'h10000; r.mass_b = 32'h10000;
    r.norm_x = 16'sd16384;
    r.vel_a_x = 32'sh10000;
    for (int f = 0; f < 4; f++) begin
      r.fixed_flags = 2'(f);
      send(r);
    end
    // Separating pair passes through unchanged.
    r.fixed_flags = 0; r.vel_a_x = -32'sh10000; send(r);
    // Zero normal velocity still takes the impulse path.
    r.vel_a_x = 32'sh5000; r.vel_b_x = 32'sh5000; send(r);
    // Both masses zero and one mass zero.
    r.vel_b_x = 0; r.mass_a = 0; r.mass_b = 0; send(r);
    r.mass_b = 32'hffffffff; send(r);
    // Extremes that clamp, with a normal off unit length.
    r.vel_a_x = 32'sh7fffffff; r.vel_b_x = 32'sh80000000;
    r.vel_a_y = 32'sh80000000; r.vel_b_y = 32'sh7fffffff;
    r.norm_y = 16'sh8000; r.norm_z = 16'sh7fff;
    r.mass_a = 32'hffffffff; send(r);
    r.fixed_flags = 1; send(r);
    r.fixed_flags = 2; send(r);
    r.norm_x = -16'sd16384; r.fixed_flags = 0; send(r);
    pause_start(1);
  endtask

  task automatic random_set(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--) send(rand_request());
      if ($urandom_range(0, 2) != 0) pause_start($urandom_range(1, 8));
    end
    pause_start(1);
  endtask

  initial begin
    logic [15:0] settings[5];
    settings = '{16'd0, 16'd32768, 16'hffff, 16'd16384, 16'd26214};
    rst_ni = 0;
    start = 0;
    cfg_valid_i = 0;
    cfg_data_i = '0;
    req_i = '0;
    requests_sent = 0;
    settings_used = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    directed_set();
    random_set(150);
    foreach (settings[i]) begin
      write_rest(settings[i]);
      if (i == 0) directed_set();
      random_set(120);
    end
    while (pending_count != 0) @(posedge clk_i);
    repeat (sir_pkg::ResultLat + 8) @(posedge clk_i);
    $display("sent %0d requests over %0d restitution settings plus reset, checked %0d results",
             requests_sent, settings_used, result_count);
    if (fail_count == 0 && pending_count == 0) $display("[sphere_impulse_response] OK");
    else $display("[sphere_impulse_response] ERROR");
    $finish;
  end
endmodule

FILE: files.f
rtl/sir_pkg.sv
rtl/sir_divider.sv
rtl/sir_delay.sv
rtl/sir_front.sv
rtl/sir_back.sv
rtl/sphere_impulse_response.sv
sim/sir_checker.sv
sim/testbench.sv
